// ----- src/elpt_pkg.sv -----
// Shared types and codes for the edit list position translator.
`default_nettype none

package elpt_pkg;

  // Default sizing of the edit table and of the offsets.
  localparam int unsigned DEF_MAX_EDITS = 64;
  localparam int unsigned DEF_POS_WIDTH = 32;

  // Width of the offset ports and of the status port.
  localparam int unsigned PORT_POS_WIDTH = 32;
  localparam int unsigned STATUS_WIDTH   = 3;

  typedef enum logic [0:0] {
    OP_APPEND    = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK       = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_ORDER    = 3'd3,
    ST_REVERSED = 3'd4
  } status_t;

  // Control part of the query token that travels down the cell chain.
  typedef struct packed {
    logic valid;  // a query occupies this link
    logic done;   // the walk has stopped; later cells pass it on untouched
    logic ins;    // the position lies in text that an edit inserted
  } tok_ctl_t;

endpackage : elpt_pkg

`default_nettype wire

// ----- src/elpt_cell.sv -----
// One cell of the edit chain: holds one stored edit and steps a query past it.
`default_nettype none

module elpt_cell
  import elpt_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned CW        = 7,
  parameter int unsigned POS_WIDTH = DEF_POS_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [CW-1:0]        count,
  input  wire logic                 wr_en,
  input  wire logic [CW-1:0]        wr_idx,
  input  wire logic [POS_WIDTH-1:0] wr_start,
  input  wire logic [POS_WIDTH:0]   wr_sl,
  input  wire logic [POS_WIDTH+1:0] wr_off,
  input  wire tok_ctl_t             tok_in,
  input  wire logic [POS_WIDTH-1:0] pos_in,
  output tok_ctl_t                  tok_out,
  output logic [POS_WIDTH-1:0]      pos_out
);

  // Stored edit: its start, start plus replacement length, and the net
  // shift (end - start - length) held modulo 2^(POS_WIDTH+2).
  logic [POS_WIDTH-1:0] start_r;
  logic [POS_WIDTH:0]   sl_r;
  logic [POS_WIDTH+1:0] off_r;

  tok_ctl_t             tok_r, tok_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;

  logic                 active;
  logic [POS_WIDTH+1:0] shifted;

  assign active  = (CW'(IDX) < count);
  assign shifted = {2'b00, pos_in} + off_r;

  always_comb begin
    tok_nxt = tok_in;
    pos_nxt = pos_in;
    if (tok_in.valid && !tok_in.done && active) begin
      if (start_r > pos_in) begin
        tok_nxt.done = 1'b1;
      end else if ({1'b0, pos_in} < sl_r) begin
        tok_nxt.done = 1'b1;
        tok_nxt.ins  = 1'b1;
      end else if (shifted[POS_WIDTH+1:POS_WIDTH] != 2'b00) begin
        pos_nxt = '1;
      end else begin
        pos_nxt = shifted[POS_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == CW'(IDX))) begin
      start_r <= wr_start;
      sl_r    <= wr_sl;
      off_r   <= wr_off;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

  assign tok_out = tok_r;
  assign pos_out = pos_r;

endmodule : elpt_cell

`default_nettype wire

// ----- src/edit_list_position_translator.sv -----
// Top level of the edit list position translator: append logic and cell chain.
//
// The block keeps an ordered list of up to MAX_EDITS text edits and maps
// post-edit offsets back to pre-edit offsets. A transaction is accepted on a
// rising edge where start is high and busy is low. in_operation selects an
// append (edit fields used) or a translate (in_query_position used).
// Every transaction gives exactly one result: out_valid is high for one cycle
// with out_status and out_pre_edit_position, and the receiver cannot stall it.
// An append is answered in the cycle after acceptance and busy stays low, so
// appends may follow one another in every cycle.
// A translate sends a query token down a chain of MAX_EDITS cells, one cell
// per cycle, each cell holding one stored edit. Its result is registered
// once the token has left the last cell. busy falls together with the result
// strobe, and the next transaction can be accepted at the edge that takes the
// result; the time per translate is set by the length of the chain. busy is
// high while the token is in flight.
// Reset empties the edit list and clears the chain; stored edit values are
// left as they are, since only entries below the edit count are ever read.
`default_nettype none

module edit_list_position_translator
  import elpt_pkg::*;
#(
  parameter int unsigned MAX_EDITS = DEF_MAX_EDITS,
  parameter int unsigned POS_WIDTH = DEF_POS_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_operation,
  input  wire logic [PORT_POS_WIDTH-1:0] in_edit_start,
  input  wire logic [PORT_POS_WIDTH-1:0] in_edit_end,
  input  wire logic [PORT_POS_WIDTH-1:0] in_replacement_length,
  input  wire logic [PORT_POS_WIDTH-1:0] in_query_position,
  output logic                           out_valid,
  output logic [STATUS_WIDTH-1:0]        out_status,
  output logic [PORT_POS_WIDTH-1:0]      out_pre_edit_position
);

  // The edit count must be able to hold MAX_EDITS itself.
  localparam int unsigned CW = $clog2(MAX_EDITS + 1);

  logic accept, acc_append, acc_translate;

  assign accept        = start && !busy;
  assign acc_append    = accept && (in_operation == OP_APPEND);
  assign acc_translate = accept && (in_operation == OP_TRANSLATE);

  // Offsets are taken modulo 2^POS_WIDTH inside the block.
  logic [POS_WIDTH-1:0] e_start, e_end, e_len, q_pos;

  assign e_start = POS_WIDTH'(in_edit_start);
  assign e_end   = POS_WIDTH'(in_edit_end);
  assign e_len   = POS_WIDTH'(in_replacement_length);
  assign q_pos   = POS_WIDTH'(in_query_position);

  // ---------------------------------------------------------------------
  // Append checks. The first failing check decides the status; a rejected
  // append leaves the list unchanged.
  // ---------------------------------------------------------------------
  logic [CW-1:0]        count_r, count_nxt;
  logic [POS_WIDTH-1:0] last_end_r;
  status_t              app_status;
  logic                 app_ok;

  always_comb begin
    if (count_r == CW'(MAX_EDITS)) begin
      app_status = ST_FULL;
    end else if ((count_r != '0) && (e_start < last_end_r)) begin
      app_status = ST_ORDER;
    end else if (e_end < e_start) begin
      app_status = ST_REVERSED;
    end else begin
      app_status = ST_OK;
    end
  end

  assign app_ok = acc_append && (app_status == ST_OK);

  // Values precomputed for the cell so that its per-cycle work is two
  // compares and one add: start + length, and the net shift of the edit.
  logic [POS_WIDTH:0]   wr_sl;
  logic [POS_WIDTH+1:0] wr_off;

  assign wr_sl  = {1'b0, e_start} + {1'b0, e_len};
  assign wr_off = {2'b00, e_end} - {1'b0, wr_sl};

  always_comb begin
    count_nxt = count_r;
    if (app_ok) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // The previous edit's end is only consulted while the count is non-zero.
  always_ff @(posedge clk) begin
    if (app_ok) begin
      last_end_r <= e_end;
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain. Link 0 is the injection point, link MAX_EDITS the result.
  // ---------------------------------------------------------------------
  tok_ctl_t             chain_ctl [MAX_EDITS+1];
  logic [POS_WIDTH-1:0] chain_pos [MAX_EDITS+1];
  logic [MAX_EDITS-1:0] link_valid;

  assign chain_ctl[0] = '{valid: acc_translate, done: 1'b0, ins: 1'b0};

  assign chain_pos[0] = q_pos;

  for (genvar gi = 0; gi < MAX_EDITS; gi++) begin : g_cell
    elpt_cell #(
      .IDX       (gi),
      .CW        (CW),
      .POS_WIDTH (POS_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .count    (count_r),
      .wr_en    (app_ok),
      .wr_idx   (count_r),
      .wr_start (e_start),
      .wr_sl    (wr_sl),
      .wr_off   (wr_off),
      .tok_in   (chain_ctl[gi]),
      .pos_in   (chain_pos[gi]),
      .tok_out  (chain_ctl[gi+1]),
      .pos_out  (chain_pos[gi+1])
    );
    assign link_valid[gi] = chain_ctl[gi+1].valid;
  end

  tok_ctl_t             last_ctl;
  logic [POS_WIDTH-1:0] last_pos;

  assign last_ctl = chain_ctl[MAX_EDITS];
  assign last_pos = chain_pos[MAX_EDITS];

  // ---------------------------------------------------------------------
  // Busy flag and result register.
  // ---------------------------------------------------------------------
  logic                      busy_r, busy_nxt;
  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [PORT_POS_WIDTH-1:0] out_pos_r, out_pos_nxt;

  always_comb begin
    busy_nxt = busy_r;
    if (acc_translate) begin
      busy_nxt = 1'b1;
    end else if (last_ctl.valid) begin
      busy_nxt = 1'b0;
    end
  end

  // Appends and translates never finish in the same cycle, as a translate
  // holds busy until its token leaves the chain.
  always_comb begin
    out_valid_nxt  = acc_append || last_ctl.valid;
    out_status_nxt = ST_OK;
    out_pos_nxt    = '0;
    if (acc_append) begin
      out_status_nxt = app_status;
    end else if (last_ctl.ins) begin
      out_status_nxt = ST_INSERTED;
    end else begin
      out_pos_nxt = PORT_POS_WIDTH'(last_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign busy                  = busy_r;
  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_pre_edit_position = out_pos_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------

  // The count never passes the size of the list.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EDITS))
    else $error("edit count exceeds list size");

  // The count only moves on an accepted append.
  a_count_cause : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(acc_append))
    else $error("edit count changed without an append");

  // At most one query token is in the chain at any time.
  a_one_token : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(link_valid) <= 1)
    else $error("more than one query in the chain");

  // A translate keeps the block busy in the following cycle.
  a_busy_after : assert property (@(posedge clk) disable iff (!rst_n)
    acc_translate |=> busy)
    else $error("busy not raised after a translate");

  // Any result whose status is not OK carries a zero offset.
  a_zero_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_pre_edit_position == '0))
    else $error("non-zero offset on a failed result");

endmodule : edit_list_position_translator

`default_nettype wire
